// ----- hw/rtl/rgbcv_pkg.sv -----
// Shared constants and types for the RGB 3x3 convolution block.
`default_nettype none
package rgbcv_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WID_W      = ADDR_W + 1;
  localparam int HGT_W      = 12;
  localparam int CNT_W      = 22;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int KDIM       = 3;
  localparam int WGT_W      = 16;
  localparam int KROW_W     = KDIM * WGT_W;
  localparam int SCL_W      = 16;
  localparam int MUL_W      = CH_W + 1 + WGT_W;
  localparam int ACC_W      = MUL_W + 3;
  localparam int PROD_W     = ACC_W + SCL_W + 1;
  localparam int FRAC_W     = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KROW_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_KROW_TOP     = 3'd2,
    CFG_KROW_MID     = 3'd3,
    CFG_KROW_BOT     = 3'd4,
    CFG_SCALE        = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // taps and weights indexed [row][col]
  typedef logic [KDIM-1:0][KDIM-1:0][PIX_W-1:0] win_t;
  typedef logic [KDIM-1:0][KDIM-1:0][WGT_W-1:0] kern_t;
endpackage
`default_nettype wire

// ----- hw/rtl/rgbcv_filter.sv -----
// Iterative multiply-accumulate over nine taps, scale and saturate, one unit per channel.
`default_nettype none
module rgbcv_filter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  rgbcv_pkg::win_t           taps,
  input  rgbcv_pkg::kern_t          kern,
  input  logic [rgbcv_pkg::SCL_W-1:0] scale,
  output logic                      res_vld,
  input  logic                      res_take,
  output rgbcv_pkg::rgb_t           res
);
  import rgbcv_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_MAC   = 4'b0010,
    F_SCALE = 4'b0100,
    F_DONE  = 4'b1000
  } fstate_t;

  fstate_t                  fstate_r, fstate_nxt;
  logic [1:0]               ky_r, kx_r;
  logic signed [ACC_W-1:0]  acc_r  [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic [PIX_W-1:0]         tap;
  logic signed [WGT_W-1:0]  wgt;
  logic signed [MUL_W-1:0]  mprod  [3];
  logic                     last_tap;

  function automatic logic [CH_W-1:0] saturate(input logic signed [PROD_W-1:0] p);
    logic [CH_W-1:0] v;
    if (p[PROD_W-1] || p == '0) begin
      v = '0;
    end else if (|p[PROD_W-1:FRAC_W+CH_W]) begin
      v = '1;
    end else begin
      v = p[FRAC_W+CH_W-1:FRAC_W];
    end
    return v;
  endfunction

  assign tap      = taps[ky_r][kx_r];
  assign wgt      = $signed(kern[ky_r][kx_r]);
  assign last_tap = (ky_r == 2'd2) && (kx_r == 2'd2);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mprod[c] = $signed({1'b0, tap[(2-c)*CH_W +: CH_W]}) * wgt;
    end
  end

  always_comb begin
    fstate_nxt = fstate_r;
    case (fstate_r)
      F_IDLE:  if (start) fstate_nxt = F_MAC;
      F_MAC:   if (last_tap) fstate_nxt = F_SCALE;
      F_SCALE: fstate_nxt = F_DONE;
      F_DONE:  if (res_take) fstate_nxt = F_IDLE;
      default: fstate_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r <= F_IDLE;
    end else begin
      fstate_r <= fstate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fstate_r == F_IDLE && start) begin
      ky_r <= 2'd0;
      kx_r <= 2'd0;
      for (int c = 0; c < 3; c++) acc_r[c] <= '0;
    end else if (fstate_r == F_MAC) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + {{(ACC_W-MUL_W){mprod[c][MUL_W-1]}}, mprod[c]};
      end
      if (kx_r == 2'd2) begin
        kx_r <= 2'd0;
        ky_r <= ky_r + 2'd1;
      end else begin
        kx_r <= kx_r + 2'd1;
      end
    end else if (fstate_r == F_SCALE) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= acc_r[c] * $signed({1'b0, scale});
      end
    end
  end

  assign res_vld   = (fstate_r == F_DONE);
  assign res.red   = saturate(prod_r[0]);
  assign res.green = saturate(prod_r[1]);
  assign res.blue  = saturate(prod_r[2]);
endmodule
`default_nettype wire

// ----- hw/rtl/rgb_conv3x3_clamp_top.sv -----
// Path: a word that yields a pixel passes the update state, the tap register, the filter's
//   nine-step multiply-accumulate, scale and done states, then the output word register.
// The line-store read and update come first; no new word is taken until the last is through.
// Line stores: one read and at most one write per word, so accesses never overlap.
// Reset (rst_n low, synchronous): state, counters, window, flags, output valid and
//   configuration registers to defaults; line stores are not cleared, edge repetition keeps unwritten entries unused.
`default_nettype none
module rgb_conv3x3_clamp_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [rgbcv_pkg::CH_W-1:0]      in_red_in,
  input  logic [rgbcv_pkg::CH_W-1:0]      in_green_in,
  input  logic [rgbcv_pkg::CH_W-1:0]      in_blue_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rgbcv_pkg::CH_W-1:0]      out_red_out,
  output logic [rgbcv_pkg::CH_W-1:0]      out_green_out,
  output logic [rgbcv_pkg::CH_W-1:0]      out_blue_out,
  output logic                            out_frame_last,
  input  logic                            cfg_we,
  input  logic [rgbcv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbcv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rgbcv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_UPD  = 3'b010,
    S_FILT = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [WID_W-1:0]     width_r;
  logic [HGT_W-1:0]     height_r;
  kern_t                kern_r;
  logic [SCL_W-1:0]     scale_r;
  logic [CNT_W-1:0]     total_r;

  logic [PIX_W-1:0]     upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0]     lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0]     t_rd_r, m_rd_r;

  logic                 cmd_r;
  logic [PIX_W-1:0]     pix_r;
  logic [ADDR_W-1:0]    col_r, col_nxt;
  logic [HGT_W-1:0]     row_r, row_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 final_r, final_nxt;
  win_t                 win_r, win_new, src, taps_r, taps_nxt;
  logic                 last_r;

  logic [WID_W-1:0]     w_eff;
  logic [HGT_W-1:0]     h_eff;
  logic                 accept, upd, pixel_slot, ignore, emit, use_old, last;
  logic                 row_ge1, row_ge2, restart, start;
  logic [PIX_W-1:0]     newpix;
  logic [WID_W-1:0]     col_p1;
  logic [CNT_W-1:0]     cnt_inc;
  logic [KDIM-1:0][1:0] rs, cs;

  logic                 res_vld, res_take;
  rgb_t                 res;
  logic                 out_valid_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(MAX_WIDTH);
      height_r <= HGT_W'(1);
      kern_r   <= {KROW_W'(0), KROW_W'(48'h0000_0100_0000), KROW_W'(0)};
      scale_r  <= SCL_W'(32768);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r   <= cfg_data[WID_W-1:0];
        CFG_IMAGE_HEIGHT: height_r  <= cfg_data[HGT_W-1:0];
        CFG_KROW_TOP:     kern_r[0] <= cfg_data[KROW_W-1:0];
        CFG_KROW_MID:     kern_r[1] <= cfg_data[KROW_W-1:0];
        CFG_KROW_BOT:     kern_r[2] <= cfg_data[KROW_W-1:0];
        CFG_SCALE:        scale_r   <= cfg_data[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (width_r == '0) ? WID_W'(1) :
                 (width_r > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? HGT_W'(1) : height_r;

  always_ff @(posedge clk) begin
    total_r <= {{(CNT_W-HGT_W){1'b0}}, h_eff} * {{(CNT_W-WID_W){1'b0}}, w_eff};
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign upd      = (state_r == S_UPD);

  // line stores: read on accept, write back in the update cycle unless the word is ignored
  always_ff @(posedge clk) begin
    if (accept) begin
      t_rd_r <= upper_mem[col_r];
      m_rd_r <= lower_mem[col_r];
    end
    if (upd && !ignore) begin
      upper_mem[col_r] <= m_rd_r;
      lower_mem[col_r] <= newpix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      pix_r <= {in_red_in, in_green_in, in_blue_in};
    end
  end

  always_comb begin
    pixel_slot = !final_r && (row_r < h_eff);
    ignore     = cmd_r && pixel_slot;
    newpix     = pixel_slot ? pix_r : '0;
    row_ge1    = final_r || (row_r != '0);
    row_ge2    = final_r || (row_r >= HGT_W'(2));
    emit       = (row_ge2 || (row_ge1 && col_r != '0)) && (cnt_r < total_r);
    use_old    = (col_r == '0);
    last       = (cnt_r == total_r - CNT_W'(1));

    for (int k = 0; k < KDIM; k++) begin
      win_new[k][0] = win_r[k][1];
      win_new[k][1] = win_r[k][2];
    end
    win_new[0][2] = t_rd_r;
    win_new[1][2] = m_rd_r;
    win_new[2][2] = newpix;
    src = use_old ? win_r : win_new;

    // clamp-to-edge row and column picks
    rs[0] = (cnt_r < CNT_W'(w_eff)) ? 2'd1 : 2'd0;
    rs[1] = 2'd1;
    rs[2] = (({1'b0, cnt_r} + (CNT_W+1)'(w_eff)) >= {1'b0, total_r}) ? 2'd1 : 2'd2;
    if (use_old) begin
      cs[0] = (w_eff == WID_W'(1)) ? 2'd2 : 2'd1;
      cs[1] = 2'd2;
      cs[2] = 2'd2;
    end else begin
      cs[0] = (col_r == ADDR_W'(1)) ? 2'd1 : 2'd0;
      cs[1] = 2'd1;
      cs[2] = ({1'b0, col_r} >= w_eff) ? 2'd1 : 2'd2;
    end
    for (int ky = 0; ky < KDIM; ky++) begin
      for (int kx = 0; kx < KDIM; kx++) begin
        taps_nxt[ky][kx] = src[rs[ky]][cs[kx]];
      end
    end

    cnt_inc   = cnt_r + CNT_W'(1);
    cnt_nxt   = emit ? cnt_inc : cnt_r;
    col_p1    = {1'b0, col_r} + WID_W'(1);
    row_nxt   = row_r;
    final_nxt = final_r;
    if (col_p1 >= w_eff) begin
      col_nxt = '0;
      if (row_r >= h_eff) begin
        final_nxt = 1'b1;
      end else begin
        row_nxt = row_r + HGT_W'(1);
      end
    end else begin
      col_nxt = col_p1[ADDR_W-1:0];
    end
    restart = final_r || (emit && cnt_inc >= total_r);
    if (restart) begin
      col_nxt   = '0;
      row_nxt   = '0;
      cnt_nxt   = '0;
      final_nxt = 1'b0;
    end
  end

  assign start = upd && !ignore && emit;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_UPD;
      S_UPD:   state_nxt = start ? S_FILT : S_IDLE;
      S_FILT:  if (res_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
      final_r <= 1'b0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (upd && !ignore) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        cnt_r   <= cnt_nxt;
        final_r <= final_nxt;
        win_r   <= win_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      taps_r <= taps_nxt;
      last_r <= last;
    end
  end

  rgbcv_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .taps     (taps_r),
    .kern     (kern_r),
    .scale    (scale_r),
    .res_vld  (res_vld),
    .res_take (res_take),
    .res      (res)
  );

  // output word register
  assign res_take = res_vld && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_red_out    <= res.red;
      out_green_out  <= res.green;
      out_blue_out   <= res.blue;
      out_frame_last <= last_r;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// ----- hw/rtl/rgbcv_chk.sv -----
// Port-level checks for the RGB 3x3 convolution block, bound to the top level.
`default_nettype none
module rgbcv_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rgbcv_pkg::CH_W-1:0] out_red_out,
  input logic [rgbcv_pkg::CH_W-1:0] out_green_out,
  input logic [rgbcv_pkg::CH_W-1:0] out_blue_out,
  input logic                       out_frame_last
);
  import rgbcv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red_out) && $stable(out_green_out) &&
                                $stable(out_blue_out) && $stable(out_frame_last))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("block not busy after taking a word");

  a_out_retire: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) && $past(rst_n) |-> $past(out_ready))
    else $error("output word retired without being taken");
endmodule

bind rgb_conv3x3_clamp_top rgbcv_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_red_out    (out_red_out),
  .out_green_out  (out_green_out),
  .out_blue_out   (out_blue_out),
  .out_frame_last (out_frame_last)
);
`default_nettype wire
